// ===== rtl/stt_pkg.sv =====
package stt_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int LINE_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH     = 8;

    // scan modes of the tokenizer
    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_SLASH   = 4'd1,
        M_LINEC   = 4'd2,
        M_BLOCKC  = 4'd3,
        M_STAR    = 4'd4,
        M_IDENT   = 4'd5,
        M_ZERO    = 4'd6,
        M_DEC     = 4'd7,
        M_HEX     = 4'd8,
        M_BIN     = 4'd9,
        M_DOT     = 4'd10,
        M_EXP     = 4'd11,
        M_EXPSIGN = 4'd12,
        M_EXPDIG  = 4'd13,
        M_STRING  = 4'd14,
        M_ESC     = 4'd15
    } mode_t;

    // controller states
    typedef enum logic [1:0] {
        S_WAIT  = 2'd0,
        S_SCAN  = 2'd1,
        S_DRAIN = 2'd2
    } ctrl_state_t;

    // token types
    localparam logic [2:0] TT_EOF     = 3'd0;
    localparam logic [2:0] TT_COMMENT = 3'd1;
    localparam logic [2:0] TT_IDENT   = 3'd2;
    localparam logic [2:0] TT_INTEGER = 3'd3;
    localparam logic [2:0] TT_FLOAT   = 3'd4;
    localparam logic [2:0] TT_STRING  = 3'd5;
    localparam logic [2:0] TT_SYMBOL  = 3'd6;
    localparam logic [2:0] TT_INVALID = 3'd7;

    // number mark bits
    localparam int NM_FLOAT = 0;
    localparam int NM_HEX   = 1;
    localparam int NM_BIN   = 2;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic step;
        logic drain;
    } stt_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic queue_empty;
        logic pend_valid;
        logic out_free;
    } stt_stat_t;

endpackage

// ===== rtl/stt_ctrl.sv =====
module stt_ctrl
    import stt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  stt_stat_t stat,
    output stt_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_WAIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_WAIT:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.queue_empty)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!stat.pend_valid || stat.out_free)
                begin
                    state_next = S_WAIT;
                end
            end
            default:
            begin
                state_next = S_WAIT;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            S_WAIT:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            S_SCAN:
            begin
                cmd.step = !stat.queue_empty && stat.out_free;
            end
            S_DRAIN:
            begin
                cmd.drain = stat.pend_valid && stat.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/stt_datapath.sv =====
module stt_datapath
    import stt_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             text_byte,
    input  logic                   cfg_valid,
    input  logic                   cfg_data,
    input  logic                   out_stall,
    input  stt_cmd_t               cmd,
    output stt_stat_t              stat,
    output logic                   out_valid,
    output logic [2:0]             token_type,
    output logic [OFFSET_BITS-1:0] start_offset,
    output logic [OFFSET_BITS-1:0] token_length,
    output logic [LINE_BITS-1:0]   start_line,
    output logic [LINE_BITS-1:0]   start_column,
    output logic                   block_comment,
    output logic [7:0]             symbol_byte,
    output logic                   last_of_run
);

    localparam int OB = OFFSET_BITS;
    localparam int LB = LINE_BITS;
    localparam int QB = $clog2(QUEUE_DEPTH);

    function automatic logic [OB-1:0] sat_o(input logic [OB-1:0] v, input logic [2:0] k);
        logic [OB:0] s;
        s = {1'b0, v} + {{(OB - 2){1'b0}}, k};
        return s[OB] ? {OB{1'b1}} : s[OB-1:0];
    endfunction

    function automatic logic [LB-1:0] sat_l(input logic [LB-1:0] v, input logic [2:0] k);
        logic [LB:0] s;
        s = {1'b0, v} + {{(LB - 2){1'b0}}, k};
        return s[LB] ? {LB{1'b1}} : s[LB-1:0];
    endfunction

    // scanner state
    logic          utf8_reg;
    mode_t         mode_reg, mode_next;
    logic [OB-1:0] off_reg, off_next, tso_reg, tso_next;
    logic [LB-1:0] ln_reg, ln_next, col_reg, col_next;
    logic [LB-1:0] tsl_reg, tsl_next, tsc_reg, tsc_next;
    logic [2:0]    nm_reg, nm_next;
    logic [7:0]    held_reg [3];
    logic [7:0]    held_next [3];
    logic [1:0]    hcnt_reg, hcnt_next;

    // byte queue for rescans
    logic [7:0]    q_reg [QUEUE_DEPTH];
    logic [7:0]    q_next [QUEUE_DEPTH];
    logic [QB:0]   qn_reg, qn_next;

    // pending token and output register
    logic          pend_valid_reg;
    logic [2:0]    p_type_reg;
    logic [OB-1:0] p_off_reg, p_len_reg;
    logic [LB-1:0] p_ln_reg, p_col_reg;
    logic          p_blk_reg;
    logic [7:0]    p_sym_reg;

    logic          out_valid_reg;
    logic [2:0]    o_type_reg;
    logic [OB-1:0] o_off_reg, o_len_reg;
    logic [LB-1:0] o_ln_reg, o_col_reg;
    logic          o_blk_reg;
    logic [7:0]    o_sym_reg;
    logic          o_last_reg;

    // emit and push results of one step
    logic          e_valid;
    logic [2:0]    e_type;
    logic [OB-1:0] e_off, e_len;
    logic [LB-1:0] e_ln, e_col;
    logic          e_blk;
    logic [7:0]    e_sym;
    logic [7:0]    p_b [4];
    logic [2:0]    p_n;

    logic [7:0]    b;
    logic          is_dig, is_hex, id_start, out_free;

    assign b        = q_reg[0];
    assign is_dig   = (b >= "0") && (b <= "9");
    assign is_hex   = is_dig || ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"));
    assign id_start = ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"))
                      || (b == "_") || (utf8_reg && b[7]);
    assign out_free = !out_valid_reg || !out_stall;

    assign stat.queue_empty = (qn_reg == '0);
    assign stat.pend_valid  = pend_valid_reg;
    assign stat.out_free    = out_free;

    // one scan step on the head byte of the queue
    always_comb
    begin
        logic       hex;
        logic [2:0] ck;
        logic [1:0] hc;

        mode_next = mode_reg;
        off_next  = off_reg;
        ln_next   = ln_reg;
        col_next  = col_reg;
        tso_next  = tso_reg;
        tsl_next  = tsl_reg;
        tsc_next  = tsc_reg;
        nm_next   = nm_reg;
        hcnt_next = hcnt_reg;
        for (int i = 0; i < 3; i++)
        begin
            held_next[i] = held_reg[i];
        end
        e_valid = 1'b0;
        e_type  = TT_EOF;
        e_off   = off_reg;
        e_len   = '0;
        e_ln    = ln_reg;
        e_col   = col_reg;
        e_blk   = 1'b0;
        e_sym   = 8'd0;
        for (int i = 0; i < 4; i++)
        begin
            p_b[i] = 8'd0;
        end
        p_n = 3'd0;
        hex = 1'b0;
        hc  = hcnt_reg;
        ck  = {1'b0, hcnt_reg} + 3'd1;

        case (mode_reg)
            M_IDLE:
            begin
                if (b == 8'd0)
                begin
                    e_valid  = 1'b1;
                    e_type   = TT_EOF;
                    off_next = '0;
                    ln_next  = {{(LB - 1){1'b0}}, 1'b1};
                    col_next = {{(LB - 1){1'b0}}, 1'b1};
                end
                else if (b == " " || b == 8'h09 || b == 8'h0D)
                begin
                    off_next = sat_o(off_reg, 3'd1);
                    col_next = sat_l(col_reg, 3'd1);
                end
                else if (b == 8'h0A)
                begin
                    off_next = sat_o(off_reg, 3'd1);
                    ln_next  = sat_l(ln_reg, 3'd1);
                    col_next = {{(LB - 1){1'b0}}, 1'b1};
                end
                else if (b == "/" || id_start || is_dig || b == "\"")
                begin
                    tso_next = off_reg;
                    tsl_next = ln_reg;
                    tsc_next = col_reg;
                    off_next = sat_o(off_reg, 3'd1);
                    col_next = sat_l(col_reg, 3'd1);
                    if (b == "/")
                    begin
                        mode_next = M_SLASH;
                    end
                    else if (id_start)
                    begin
                        mode_next = M_IDENT;
                    end
                    else if (is_dig)
                    begin
                        nm_next   = 3'd0;
                        mode_next = (b == "0") ? M_ZERO : M_DEC;
                    end
                    else
                    begin
                        tso_next  = sat_o(off_reg, 3'd1);
                        mode_next = M_STRING;
                    end
                end
                else
                begin
                    e_valid  = 1'b1;
                    e_len    = {{(OB - 1){1'b0}}, 1'b1};
                    if (b >= 8'h20 && b <= 8'h7E)
                    begin
                        e_type = TT_SYMBOL;
                        e_sym  = b;
                    end
                    else
                    begin
                        e_type = TT_INVALID;
                    end
                    off_next = sat_o(off_reg, 3'd1);
                    col_next = sat_l(col_reg, 3'd1);
                end
            end
            M_SLASH:
            begin
                if (b == "/" || b == "*")
                begin
                    off_next  = sat_o(off_reg, 3'd1);
                    col_next  = sat_l(col_reg, 3'd1);
                    tso_next  = sat_o(off_reg, 3'd1);
                    mode_next = (b == "*") ? M_BLOCKC : M_LINEC;
                end
                else
                begin
                    e_valid   = 1'b1;
                    e_type    = TT_SYMBOL;
                    e_off     = tso_reg;
                    e_len     = {{(OB - 1){1'b0}}, 1'b1};
                    e_ln      = tsl_reg;
                    e_col     = tsc_reg;
                    e_sym     = "/";
                    mode_next = M_IDLE;
                    p_b[0]    = b;
                    p_n       = 3'd1;
                end
            end
            M_LINEC:
            begin
                if (b == 8'd0 || b == 8'h0A)
                begin
                    e_valid   = 1'b1;
                    e_type    = TT_COMMENT;
                    mode_next = M_IDLE;
                    p_b[0]    = b;
                    p_n       = 3'd1;
                end
                else
                begin
                    off_next = sat_o(off_reg, 3'd1);
                    col_next = sat_l(col_reg, 3'd1);
                end
            end
            M_BLOCKC:
            begin
                if (b == 8'd0)
                begin
                    e_valid   = 1'b1;
                    e_type    = TT_COMMENT;
                    e_blk     = 1'b1;
                    mode_next = M_IDLE;
                    p_b[0]    = b;
                    p_n       = 3'd1;
                end
                else if (b == "*")
                begin
                    if (hcnt_reg != 2'd3)
                    begin
                        held_next[hcnt_reg] = b;
                        hcnt_next = hcnt_reg + 2'd1;
                    end
                    mode_next = M_STAR;
                end
                else if (b == 8'h0A)
                begin
                    off_next = sat_o(off_reg, 3'd1);
                    ln_next  = sat_l(ln_reg, 3'd1);
                    col_next = {{(LB - 1){1'b0}}, 1'b1};
                end
                else
                begin
                    off_next = sat_o(off_reg, 3'd1);
                    col_next = sat_l(col_reg, 3'd1);
                end
            end
            M_STAR:
            begin
                hcnt_next = 2'd0;
                if (b == "/")
                begin
                    e_valid   = 1'b1;
                    e_type    = TT_COMMENT;
                    e_blk     = 1'b1;
                    off_next  = sat_o(off_reg, ck);
                    col_next  = sat_l(col_reg, ck);
                    mode_next = M_IDLE;
                end
                else
                begin
                    off_next  = sat_o(off_reg, {1'b0, hcnt_reg});
                    col_next  = sat_l(col_reg, {1'b0, hcnt_reg});
                    mode_next = M_BLOCKC;
                    p_b[0]    = b;
                    p_n       = 3'd1;
                end
            end
            M_IDENT:
            begin
                if (is_dig || id_start)
                begin
                    off_next = sat_o(off_reg, 3'd1);
                    col_next = sat_l(col_reg, 3'd1);
                end
                else
                begin
                    e_valid   = 1'b1;
                    e_type    = TT_IDENT;
                    mode_next = M_IDLE;
                    p_b[0]    = b;
                    p_n       = 3'd1;
                end
            end
            M_ZERO:
            begin
                if (b == "x" || b == "X")
                begin
                    off_next  = sat_o(off_reg, 3'd1);
                    col_next  = sat_l(col_reg, 3'd1);
                    nm_next   = 3'b010;
                    mode_next = M_HEX;
                end
                else if (b == "b" || b == "B")
                begin
                    off_next  = sat_o(off_reg, 3'd1);
                    col_next  = sat_l(col_reg, 3'd1);
                    nm_next   = 3'b100;
                    mode_next = M_BIN;
                end
                else
                begin
                    mode_next = M_DEC;
                    p_b[0]    = b;
                    p_n       = 3'd1;
                end
            end
            M_DEC, M_HEX:
            begin
                hex = (mode_reg == M_HEX);
                if (hex ? is_hex : is_dig)
                begin
                    off_next = sat_o(off_reg, 3'd1);
                    col_next = sat_l(col_reg, 3'd1);
                end
                else if ((b == "." && !nm_reg[NM_FLOAT])
                         || (hex ? (b == "p" || b == "P") : (b == "e" || b == "E")))
                begin
                    if (hcnt_reg != 2'd3)
                    begin
                        held_next[hcnt_reg] = b;
                        hcnt_next = hcnt_reg + 2'd1;
                    end
                    mode_next = (b == "." && !nm_reg[NM_FLOAT]) ? M_DOT : M_EXP;
                end
                else
                begin
                    e_valid   = 1'b1;
                    e_type    = nm_reg[NM_FLOAT] ? TT_FLOAT : TT_INTEGER;
                    mode_next = M_IDLE;
                    p_b[0]    = b;
                    p_n       = 3'd1;
                end
            end
            M_BIN, M_EXPDIG:
            begin
                if ((mode_reg == M_BIN) ? (b == "0" || b == "1") : is_dig)
                begin
                    off_next = sat_o(off_reg, 3'd1);
                    col_next = sat_l(col_reg, 3'd1);
                end
                else
                begin
                    e_valid   = 1'b1;
                    e_type    = nm_reg[NM_FLOAT] ? TT_FLOAT : TT_INTEGER;
                    mode_next = M_IDLE;
                    p_b[0]    = b;
                    p_n       = 3'd1;
                end
            end
            M_DOT, M_EXP, M_EXPSIGN:
            begin
                hex = nm_reg[NM_HEX];
                if ((mode_reg == M_DOT) ? (hex ? is_hex : is_dig) : is_dig)
                begin
                    off_next  = sat_o(off_reg, ck);
                    col_next  = sat_l(col_reg, ck);
                    hcnt_next = 2'd0;
                    nm_next   = nm_reg | 3'b001;
                    if (mode_reg == M_DOT)
                    begin
                        mode_next = hex ? M_HEX : M_DEC;
                    end
                    else
                    begin
                        mode_next = M_EXPDIG;
                    end
                end
                else if (mode_reg == M_EXP && (b == "+" || b == "-"))
                begin
                    if (hcnt_reg != 2'd3)
                    begin
                        held_next[hcnt_reg] = b;
                        hcnt_next = hcnt_reg + 2'd1;
                    end
                    mode_next = M_EXPSIGN;
                end
                else
                begin
                    // number ends before the held bytes, which are rescanned
                    e_valid   = 1'b1;
                    e_type    = nm_reg[NM_FLOAT] ? TT_FLOAT : TT_INTEGER;
                    hcnt_next = 2'd0;
                    mode_next = M_IDLE;
                    for (int i = 0; i < 4; i++)
                    begin
                        if (i < 3 && i < int'(hc))
                        begin
                            p_b[i] = held_reg[i[1:0]];
                        end
                        else if (i == int'(hc))
                        begin
                            p_b[i] = b;
                        end
                    end
                    p_n = ck;
                end
            end
            M_STRING:
            begin
                if (b == 8'd0)
                begin
                    e_valid   = 1'b1;
                    e_type    = TT_STRING;
                    mode_next = M_IDLE;
                    p_b[0]    = b;
                    p_n       = 3'd1;
                end
                else if (b == "\\")
                begin
                    off_next  = sat_o(off_reg, 3'd1);
                    col_next  = sat_l(col_reg, 3'd1);
                    mode_next = M_ESC;
                end
                else if (b == "\"")
                begin
                    e_valid   = 1'b1;
                    e_type    = TT_STRING;
                    off_next  = sat_o(off_reg, 3'd1);
                    col_next  = sat_l(col_reg, 3'd1);
                    mode_next = M_IDLE;
                end
                else if (b == 8'h0A)
                begin
                    off_next = sat_o(off_reg, 3'd1);
                    ln_next  = sat_l(ln_reg, 3'd1);
                    col_next = {{(LB - 1){1'b0}}, 1'b1};
                end
                else
                begin
                    off_next = sat_o(off_reg, 3'd1);
                    col_next = sat_l(col_reg, 3'd1);
                end
            end
            default:
            begin
                // escape: one byte of body, end of source is rescanned
                mode_next = M_STRING;
                if (b == 8'd0)
                begin
                    p_b[0] = b;
                    p_n    = 3'd1;
                end
                else
                begin
                    off_next = sat_o(off_reg, 3'd1);
                    col_next = sat_l(col_reg, 3'd1);
                end
            end
        endcase

        // started tokens take position from the token start registers
        if (e_valid && e_type != TT_EOF && e_type != TT_SYMBOL && e_type != TT_INVALID)
        begin
            e_off = tso_reg;
            e_len = (off_reg >= tso_reg) ? (off_reg - tso_reg) : '0;
            e_ln  = tsl_reg;
            e_col = tsc_reg;
        end
    end

    // queue after a step: pushed bytes ahead of the rest
    always_comb
    begin
        logic [QB+1:0] idx;
        logic [QB+1:0] total;
        logic          do_push;

        total   = {1'b0, qn_reg} - {{(QB + 1){1'b0}}, 1'b1} + {{(QB - 1){1'b0}}, p_n};
        do_push = (total <= (QB + 2)'(QUEUE_DEPTH));
        qn_next = do_push ? total[QB:0] : (qn_reg - {{QB{1'b0}}, 1'b1});
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            idx = do_push ? ((QB + 2)'(i) + (QB + 2)'(1) - {{(QB - 1){1'b0}}, p_n})
                          : ((QB + 2)'(i) + (QB + 2)'(1));
            if (do_push && i < 4 && (i < int'(p_n)))
            begin
                q_next[i] = p_b[i[1:0]];
            end
            else if (idx < (QB + 2)'(QUEUE_DEPTH))
            begin
                q_next[i] = q_reg[idx[QB-1:0]];
            end
            else
            begin
                q_next[i] = 8'd0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            utf8_reg       <= 1'b0;
            mode_reg       <= M_IDLE;
            off_reg        <= '0;
            ln_reg         <= {{(LB - 1){1'b0}}, 1'b1};
            col_reg        <= {{(LB - 1){1'b0}}, 1'b1};
            tso_reg        <= '0;
            tsl_reg        <= {{(LB - 1){1'b0}}, 1'b1};
            tsc_reg        <= {{(LB - 1){1'b0}}, 1'b1};
            nm_reg         <= 3'd0;
            hcnt_reg       <= 2'd0;
            qn_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                utf8_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                qn_reg <= {{QB{1'b0}}, 1'b1};
            end
            else if (cmd.step)
            begin
                mode_reg <= mode_next;
                off_reg  <= off_next;
                ln_reg   <= ln_next;
                col_reg  <= col_next;
                tso_reg  <= tso_next;
                tsl_reg  <= tsl_next;
                tsc_reg  <= tsc_next;
                nm_reg   <= nm_next;
                hcnt_reg <= hcnt_next;
                qn_reg   <= qn_next;
            end
            // output register load and release
            if ((cmd.step && e_valid && pend_valid_reg) || cmd.drain)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.step && e_valid)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.drain)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            q_reg[0] <= text_byte;
        end
        else if (cmd.step)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                q_reg[i] <= q_next[i];
            end
            for (int i = 0; i < 3; i++)
            begin
                held_reg[i] <= held_next[i];
            end
        end
        if ((cmd.step && e_valid && pend_valid_reg) || cmd.drain)
        begin
            o_type_reg <= p_type_reg;
            o_off_reg  <= p_off_reg;
            o_len_reg  <= p_len_reg;
            o_ln_reg   <= p_ln_reg;
            o_col_reg  <= p_col_reg;
            o_blk_reg  <= p_blk_reg;
            o_sym_reg  <= p_sym_reg;
            o_last_reg <= cmd.drain;
        end
        if (cmd.step && e_valid)
        begin
            p_type_reg <= e_type;
            p_off_reg  <= e_off;
            p_len_reg  <= e_len;
            p_ln_reg   <= e_ln;
            p_col_reg  <= e_col;
            p_blk_reg  <= e_blk;
            p_sym_reg  <= e_sym;
        end
    end

    assign out_valid     = out_valid_reg;
    assign token_type    = o_type_reg;
    assign start_offset  = o_off_reg;
    assign token_length  = o_len_reg;
    assign start_line    = o_ln_reg;
    assign start_column  = o_col_reg;
    assign block_comment = o_blk_reg;
    assign symbol_byte   = o_sym_reg;
    assign last_of_run   = o_last_reg;

endmodule

// ===== rtl/source_text_tokenizer.sv =====
// Streaming tokenizer for C-like source text.
// Input channel: in_valid / in_stall with text_byte; one byte per transfer,
// byte 0 ends the source and returns offset, line and column to 0, 1, 1.
// Output channel: out_valid / out_stall with one token per transfer; a byte
// may cause zero to four tokens, and last_of_run marks the final one.
// Config channel: cfg_valid / cfg_ready with cfg_data (utf8_idents); always
// ready; the user must write it only while the block is idle; not enforced.
// Each byte goes through these steps in order: accept, one scan step per queued
// byte (the byte itself and every rescanned byte), a check that sees the queue
// empty, and a drain that hands over the last token of the run. The shared scan
// step takes one queued byte per cycle while the output is not stalled; a new
// byte is accepted only after the run of the previous one is done.
// A token is seen on the outputs in the cycle after the step that finishes the
// next token or the drain step; a stalled output holds its token and blocks
// further scan steps until the transfer completes.
// Reset clears scan mode and counters and returns to waiting for a byte.
module source_text_tokenizer
    import stt_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             text_byte,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [2:0]             token_type,
    output logic [OFFSET_BITS-1:0] start_offset,
    output logic [OFFSET_BITS-1:0] token_length,
    output logic [LINE_BITS-1:0]   start_line,
    output logic [LINE_BITS-1:0]   start_column,
    output logic                   block_comment,
    output logic [7:0]             symbol_byte,
    output logic                   last_of_run
);

    stt_cmd_t  cmd;
    stt_stat_t stat;

    assign cfg_ready = 1'b1;

    // sequencer
    stt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // scanner, rescan queue and token registers
    stt_datapath #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .text_byte     (text_byte),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .out_stall     (out_stall),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .token_type    (token_type),
        .start_offset  (start_offset),
        .token_length  (token_length),
        .start_line    (start_line),
        .start_column  (start_column),
        .block_comment (block_comment),
        .symbol_byte   (symbol_byte),
        .last_of_run   (last_of_run)
    );

endmodule

// ===== rtl/stt_checker.sv =====
module stt_checker
    import stt_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [2:0]             token_type,
    input logic [OFFSET_BITS-1:0] token_length,
    input logic [7:0]             symbol_byte,
    input logic                   last_of_run
);

    // stalled token holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(token_type)
            && $stable(token_length) && $stable(last_of_run))
        else $error("stalled token changed");

    // one byte at a time: input stalls after a transfer
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted back to back");

    // end of source token is empty
    a_eof_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_type == TT_EOF |-> token_length == '0)
        else $error("eof token with length");

    // symbol byte only on symbol tokens
    a_sym: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_type != TT_SYMBOL |-> symbol_byte == 8'd0)
        else $error("symbol byte on non-symbol token");

endmodule

bind source_text_tokenizer stt_checker #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS)
) u_stt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_type   (token_type),
    .token_length (token_length),
    .symbol_byte  (symbol_byte),
    .last_of_run  (last_of_run)
);

// ===== verif/tb_source_text_tokenizer.sv =====
`timescale 1ns / 1ps

module tb_source_text_tokenizer;
    import stt_pkg::*;

    localparam int  OFF_W = OFFSET_BITS_DEF;
    localparam int  LIN_W = LINE_BITS_DEF;
    localparam logic [OFF_W-1:0] OFF_SAT = '1;
    localparam logic [LIN_W-1:0] LIN_SAT = '1;
    localparam logic [LIN_W-1:0] LIN_ONE = LIN_W'(1);
    localparam logic [OFF_W-1:0] OFF_ONE = OFF_W'(1);
    localparam int  STALL_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]       kind;
        logic [OFF_W-1:0] offs;
        logic [OFF_W-1:0] len;
        logic [LIN_W-1:0] line;
        logic [LIN_W-1:0] col;
        logic             blk;
        logic [7:0]       sym;
        logic             last;
    } token_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [7:0]       text_byte;
    logic             cfg_valid;
    logic             cfg_ready;
    logic             cfg_data;
    logic             out_valid;
    logic             out_stall;
    logic [2:0]       token_type;
    logic [OFF_W-1:0] start_offset;
    logic [OFF_W-1:0] token_length;
    logic [LIN_W-1:0] start_line;
    logic [LIN_W-1:0] start_column;
    logic             block_comment;
    logic [7:0]       symbol_byte;
    logic             last_of_run;

    source_text_tokenizer dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .text_byte(text_byte),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_stall(out_stall),
        .token_type(token_type), .start_offset(start_offset),
        .token_length(token_length), .start_line(start_line),
        .start_column(start_column), .block_comment(block_comment),
        .symbol_byte(symbol_byte), .last_of_run(last_of_run)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // predictor state
    logic             utf8_en;
    mode_t            mode;
    logic [OFF_W-1:0] cur_off, tok_off;
    logic [LIN_W-1:0] cur_line, cur_col, tok_line, tok_col;
    logic [2:0]       nmarks;
    logic [7:0]       held [3];
    int               held_n;
    logic [7:0]       rescan_q [$];
    token_t           run_tokens [$];
    token_t           expected_tokens [$];

    logic [7:0]       byte_q [$];
    int               in_idle_pct, out_idle_pct;
    bit               hold_off;
    int               hold_cnt;
    int               idle_cycles;
    int               errors;
    bit               stim_done;

    function automatic logic [OFF_W-1:0] off_add(logic [OFF_W-1:0] v, int k);
        logic [OFF_W:0] s;
        s = {1'b0, v} + (OFF_W + 1)'(k);
        return s[OFF_W] ? OFF_SAT : s[OFF_W-1:0];
    endfunction

    function automatic logic [LIN_W-1:0] lin_add(logic [LIN_W-1:0] v, int k);
        logic [LIN_W:0] s;
        s = {1'b0, v} + (LIN_W + 1)'(k);
        return s[LIN_W] ? LIN_SAT : s[LIN_W-1:0];
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_hex(logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic bit id_start(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_"
            || (utf8_en && c >= 8'h80);
    endfunction

    task automatic step_pos(int k);
        cur_off = off_add(cur_off, k);
        cur_col = lin_add(cur_col, k);
    endtask

    task automatic new_line();
        cur_off = off_add(cur_off, 1);
        cur_line = lin_add(cur_line, 1);
        cur_col = LIN_ONE;
    endtask

    task automatic mark_token();
        tok_off = cur_off;
        tok_line = cur_line;
        tok_col = cur_col;
    endtask

    task automatic add_token(logic [2:0] k, logic [OFF_W-1:0] o, logic [OFF_W-1:0] l,
                             logic [LIN_W-1:0] ln, logic [LIN_W-1:0] c,
                             logic b, logic [7:0] s);
        token_t t;
        t = '{kind: k, offs: o, len: l, line: ln, col: c, blk: b, sym: s, last: 1'b0};
        if (run_tokens.size() < 4)
            run_tokens.push_back(t);
    endtask

    task automatic add_open_token(logic [2:0] k, logic b);
        add_token(k, tok_off, (cur_off >= tok_off) ? cur_off - tok_off : '0,
                  tok_line, tok_col, b, 8'h00);
    endtask

    task automatic finish_number();
        add_open_token(nmarks[NM_FLOAT] ? TT_FLOAT : TT_INTEGER, 1'b0);
    endtask

    task automatic rescan_now(logic [7:0] b);
        mode = M_IDLE;
        rescan_q.push_front(b);
    endtask

    task automatic hold_byte(logic [7:0] b, mode_t m);
        if (held_n < 3)
        begin
            held[held_n] = b;
            held_n++;
        end
        mode = m;
    endtask

    task automatic commit_held(int extra);
        step_pos(held_n + extra);
        held_n = 0;
    endtask

    // number ends before held bytes, which are rescanned with b
    task automatic return_held(logic [7:0] b);
        finish_number();
        rescan_q.push_front(b);
        for (int i = held_n - 1; i >= 0; i--)
            rescan_q.push_front(held[i]);
        held_n = 0;
        mode = M_IDLE;
    endtask

    task automatic scan_from_idle(logic [7:0] b);
        if (b == 8'h00)
        begin
            add_token(TT_EOF, cur_off, '0, cur_line, cur_col, 1'b0, 8'h00);
            cur_off = '0;
            cur_line = LIN_ONE;
            cur_col = LIN_ONE;
        end
        else if (b == " " || b == 8'h09 || b == 8'h0d)
            step_pos(1);
        else if (b == 8'h0a)
            new_line();
        else if (b == "/")
        begin
            mark_token();
            step_pos(1);
            mode = M_SLASH;
        end
        else if (id_start(b))
        begin
            mark_token();
            step_pos(1);
            mode = M_IDENT;
        end
        else if (is_digit(b))
        begin
            mark_token();
            step_pos(1);
            nmarks = '0;
            mode = (b == "0") ? M_ZERO : M_DEC;
        end
        else if (b == "\"")
        begin
            mark_token();
            step_pos(1);
            tok_off = cur_off;
            mode = M_STRING;
        end
        else if (b >= 8'h20 && b <= 8'h7e)
        begin
            add_token(TT_SYMBOL, cur_off, OFF_ONE, cur_line, cur_col, 1'b0, b);
            step_pos(1);
        end
        else
        begin
            add_token(TT_INVALID, cur_off, OFF_ONE, cur_line, cur_col, 1'b0, 8'h00);
            step_pos(1);
        end
    endtask

    task automatic scan_byte(logic [7:0] b);
        bit hx;
        case (mode)
            M_IDLE: scan_from_idle(b);
            M_SLASH:
                if (b == "/" || b == "*")
                begin
                    step_pos(1);
                    tok_off = cur_off;
                    mode = (b == "*") ? M_BLOCKC : M_LINEC;
                end
                else
                begin
                    add_token(TT_SYMBOL, tok_off, OFF_ONE, tok_line, tok_col, 1'b0, "/");
                    rescan_now(b);
                end
            M_LINEC:
                if (b == 8'h00 || b == 8'h0a)
                begin
                    add_open_token(TT_COMMENT, 1'b0);
                    rescan_now(b);
                end
                else
                    step_pos(1);
            M_BLOCKC:
                if (b == 8'h00)
                begin
                    add_open_token(TT_COMMENT, 1'b1);
                    rescan_now(b);
                end
                else if (b == "*")
                    hold_byte(b, M_STAR);
                else if (b == 8'h0a)
                    new_line();
                else
                    step_pos(1);
            M_STAR:
                if (b == "/")
                begin
                    add_open_token(TT_COMMENT, 1'b1);
                    commit_held(1);
                    mode = M_IDLE;
                end
                else
                begin
                    commit_held(0);
                    mode = M_BLOCKC;
                    rescan_q.push_front(b);
                end
            M_IDENT:
                if (is_digit(b) || id_start(b))
                    step_pos(1);
                else
                begin
                    add_open_token(TT_IDENT, 1'b0);
                    rescan_now(b);
                end
            M_ZERO:
                if (b == "x" || b == "X")
                begin
                    step_pos(1);
                    nmarks = 3'b010;
                    mode = M_HEX;
                end
                else if (b == "b" || b == "B")
                begin
                    step_pos(1);
                    nmarks = 3'b100;
                    mode = M_BIN;
                end
                else
                begin
                    mode = M_DEC;
                    rescan_q.push_front(b);
                end
            M_DEC, M_HEX:
            begin
                hx = (mode == M_HEX);
                if (hx ? is_hex(b) : is_digit(b))
                    step_pos(1);
                else if (b == "." && !nmarks[NM_FLOAT])
                    hold_byte(b, M_DOT);
                else if (hx ? (b == "p" || b == "P") : (b == "e" || b == "E"))
                    hold_byte(b, M_EXP);
                else
                begin
                    finish_number();
                    rescan_now(b);
                end
            end
            M_DOT:
            begin
                hx = nmarks[NM_HEX];
                if (hx ? is_hex(b) : is_digit(b))
                begin
                    commit_held(1);
                    nmarks[NM_FLOAT] = 1'b1;
                    mode = hx ? M_HEX : M_DEC;
                end
                else
                    return_held(b);
            end
            M_BIN:
                if (b == "0" || b == "1")
                    step_pos(1);
                else
                begin
                    finish_number();
                    rescan_now(b);
                end
            M_EXP:
                if (b == "+" || b == "-")
                    hold_byte(b, M_EXPSIGN);
                else if (is_digit(b))
                begin
                    commit_held(1);
                    nmarks[NM_FLOAT] = 1'b1;
                    mode = M_EXPDIG;
                end
                else
                    return_held(b);
            M_EXPSIGN:
                if (is_digit(b))
                begin
                    commit_held(1);
                    nmarks[NM_FLOAT] = 1'b1;
                    mode = M_EXPDIG;
                end
                else
                    return_held(b);
            M_EXPDIG:
                if (is_digit(b))
                    step_pos(1);
                else
                begin
                    finish_number();
                    rescan_now(b);
                end
            M_STRING:
                if (b == 8'h00)
                begin
                    add_open_token(TT_STRING, 1'b0);
                    rescan_now(b);
                end
                else if (b == "\\")
                begin
                    step_pos(1);
                    mode = M_ESC;
                end
                else if (b == "\"")
                begin
                    add_open_token(TT_STRING, 1'b0);
                    step_pos(1);
                    mode = M_IDLE;
                end
                else if (b == 8'h0a)
                    new_line();
                else
                    step_pos(1);
            default:
            begin
                mode = M_STRING;
                if (b == 8'h00)
                    rescan_q.push_front(b);
                else
                    step_pos(1);
            end
        endcase
    endtask

    // expected tokens for one accepted byte
    task automatic predict_tokens(logic [7:0] b);
        int guard;
        guard = 0;
        run_tokens.delete();
        rescan_q.delete();
        rescan_q.push_back(b);
        while (rescan_q.size() > 0 && guard < 32)
        begin
            scan_byte(rescan_q.pop_front());
            guard++;
        end
        if (run_tokens.size() > 0)
            run_tokens[run_tokens.size() - 1].last = 1'b1;
        foreach (run_tokens[i])
            expected_tokens.push_back(run_tokens[i]);
    endtask

    // byte sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            text_byte <= 8'h00;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_tokens(text_byte);
            if (!in_valid || !in_stall)
            begin
                if (byte_q.size() > 0 && $urandom_range(99) >= in_idle_pct)
                begin
                    in_valid <= 1'b1;
                    text_byte <= byte_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // token receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        token_t exp_tok;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_cnt <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $error("token with none expected: type %0d offset %0d",
                           token_type, start_offset);
                    errors++;
                end
                else
                begin
                    exp_tok = expected_tokens.pop_front();
                    if (token_type !== exp_tok.kind)
                    begin
                        $error("token_type exp %0d got %0d", exp_tok.kind, token_type);
                        errors++;
                    end
                    if (start_offset !== exp_tok.offs)
                    begin
                        $error("start_offset exp %0d got %0d", exp_tok.offs, start_offset);
                        errors++;
                    end
                    if (token_length !== exp_tok.len)
                    begin
                        $error("token_length exp %0d got %0d", exp_tok.len, token_length);
                        errors++;
                    end
                    if (start_line !== exp_tok.line)
                    begin
                        $error("start_line exp %0d got %0d", exp_tok.line, start_line);
                        errors++;
                    end
                    if (start_column !== exp_tok.col)
                    begin
                        $error("start_column exp %0d got %0d", exp_tok.col, start_column);
                        errors++;
                    end
                    if (block_comment !== exp_tok.blk)
                    begin
                        $error("block_comment exp %0d got %0d", exp_tok.blk, block_comment);
                        errors++;
                    end
                    if (symbol_byte !== exp_tok.sym)
                    begin
                        $error("symbol_byte exp %0h got %0h", exp_tok.sym, symbol_byte);
                        errors++;
                    end
                    if (last_of_run !== exp_tok.last)
                    begin
                        $error("last_of_run exp %0d got %0d", exp_tok.last, last_of_run);
                        errors++;
                    end
                end
            end
            // long hold-off so the block backs up into its input
            if (hold_off && hold_cnt < 300)
            begin
                hold_cnt <= hold_cnt + 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (stim_done && expected_tokens.size() == 0))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT)
            begin
                $display("source_text_tokenizer verification failed");
                $finish;
            end
        end
    end

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            byte_q.push_back(s[i]);
    endtask

    // random piece of source text, mostly well-formed tokens
    task automatic push_random_piece();
        int n;
        n = $urandom_range(1, 6);
        case ($urandom_range(15))
            0: push_text("// note\n");
            1: push_text("/* a*b **/");
            2:
            begin
                byte_q.push_back("\"");
                repeat (n)
                    byte_q.push_back(($urandom_range(7) == 0) ? "\\"
                                                              : 8'($urandom_range(32, 126)));
                byte_q.push_back("\"");
            end
            3:
            begin
                byte_q.push_back($urandom_range(1) ? "a" : "Z");
                repeat (n)
                    byte_q.push_back($urandom_range(2) == 0 ? 8'($urandom_range(48, 57))
                                                            : 8'($urandom_range(97, 122)));
            end
            4: repeat (n) byte_q.push_back(8'($urandom_range(48, 57)));
            5:
                if ($urandom_range(1))
                    push_text("0x1f.ap-3");
                else
                    push_text("0x.");
            6:
                if ($urandom_range(1))
                    push_text("12.5e+7");
                else
                    push_text("3e-");
            7:
                if ($urandom_range(1))
                    push_text("0b1011");
                else
                    push_text("0b2");
            8:
                if ($urandom_range(1))
                    push_text("1.2.3");
                else
                    push_text("7.x");
            9:
                if ($urandom_range(1))
                    push_text("5E9");
                else
                    push_text("0xfp+");
            10: byte_q.push_back($urandom_range(1) ? " " : 8'h0a);
            11: byte_q.push_back(8'($urandom_range(128, 255)));
            12: byte_q.push_back(8'h00);
            13: byte_q.push_back(8'($urandom_range(1, 255)));
            default: byte_q.push_back(8'($urandom_range(33, 126)));
        endcase
    endtask

    task automatic wait_drained();
        while (byte_q.size() > 0 || in_valid || expected_tokens.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_utf8(logic v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        utf8_en = v;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int bytes_sent;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        in_idle_pct = 34;
        out_idle_pct = 82;
        hold_off = 1'b0;
        errors = 0;
        stim_done = 1'b0;
        idle_cycles = 0;
        utf8_en = 1'b0;
        mode = M_IDLE;
        cur_off = '0;
        tok_off = '0;
        cur_line = LIN_ONE;
        cur_col = LIN_ONE;
        tok_line = LIN_ONE;
        tok_col = LIN_ONE;
        nmarks = '0;
        held_n = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every token kind and the rescan cases
        push_text("ab_9 \t\r\n// x\n/*q**/ 0x1F 0b10 0x 0b 12.5 1..2 3.e 4e+x 7e-5");
        push_text(" 0x1.8p3 \"s\\\"t\\\n\" / ;");
        byte_q.push_back(8'h01);
        byte_q.push_back(8'hff);
        byte_q.push_back(8'h7f);
        byte_q.push_back(8'h00);
        push_text("\"open\\");
        byte_q.push_back(8'h00);
        push_text("/* never closed *");
        byte_q.push_back(8'h00);
        wait_drained();

        // utf8 identifiers enabled, with a long hold-off on the outputs
        write_utf8(1'b1);
        push_text("x");
        byte_q.push_back(8'h80);
        byte_q.push_back(8'hc3);
        push_text(" ");
        byte_q.push_back(8'hff);
        push_text("1 ");
        hold_off = 1'b1;
        bytes_sent = 0;
        while (bytes_sent < 35)
        begin
            push_random_piece();
            bytes_sent++;
        end
        wait_drained();

        // sender slow, receiver fast; back to plain identifiers
        write_utf8(1'b0);
        in_idle_pct = 82;
        out_idle_pct = 34;
        repeat (35) push_random_piece();
        wait_drained();

        write_utf8(1'b1);
        in_idle_pct = 0;
        out_idle_pct = 0;
        repeat (35) push_random_piece();
        byte_q.push_back(8'h00);
        while (byte_q.size() > 0 || in_valid)
            @(posedge clk);
        stim_done = 1'b1;
        while (expected_tokens.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("source_text_tokenizer verification clean");
        else
            $display("source_text_tokenizer verification failed");
        $finish;
    end

endmodule

// ===== source_text_tokenizer.f =====
rtl/stt_pkg.sv
rtl/stt_ctrl.sv
rtl/stt_datapath.sv
rtl/source_text_tokenizer.sv
rtl/stt_checker.sv
verif/tb_source_text_tokenizer.sv
